[sv/uvs_pkg.sv]
// shared types, constants and helper functions of the uv sphere cell vertex block
package uvs_pkg;

	localparam int MAX_SUBDIVISIONS = 256;
	localparam int COORD_BITS       = 16;
	localparam int FRAC_BITS        = COORD_BITS - 2;
	localparam int N_BITS           = $clog2(MAX_SUBDIVISIONS) + 1;
	localparam int REM_BITS         = N_BITS - 1;
	localparam int NUM_BITS         = N_BITS + 2;
	localparam int PHASE_BITS       = 32;
	localparam int DIV_STEPS        = NUM_BITS + 30;
	localparam int SINE_STAGES      = 7;
	localparam int PIPE_STAGES      = DIV_STEPS + SINE_STAGES + 2;
	localparam int VERTS_PER_CELL   = 6;
	localparam int CNT_BITS         = $clog2(VERTS_PER_CELL);
	localparam int PROD_SHIFT       = 60 - FRAC_BITS;
	localparam int SINE_SHIFT       = 30 - FRAC_BITS;
	localparam int RESET_SUBDIV     = 16;

	localparam int ADDR_BITS        = 3;
	localparam logic REG_SUBDIV     = 1'b0;

	// q30 coefficients of sin(pi/2 * f)
	localparam logic [30:0] COEF1 = 31'd1686629713;
	localparam logic [30:0] COEF3 = 31'd693598668;
	localparam logic [30:0] COEF5 = 31'd85569306;
	localparam logic [30:0] COEF7 = 31'd5026995;
	localparam logic [30:0] COEF9 = 31'd172272;

	typedef struct packed {
		logic u;
		logic v;
		logic last;
	} side_t;

	typedef struct packed {
		logic                q;
		logic [REM_BITS-1:0] rem;
	} div_step_t;

	// one restoring division step
	function automatic div_step_t div_step(input logic [REM_BITS-1:0] rem, input logic b,
		input logic [N_BITS-1:0] n);
		logic [N_BITS-1:0] trial;
		div_step_t r;
		trial = {rem, b};
		r.q   = (trial >= n);
		r.rem = r.q ? REM_BITS'(trial - n) : REM_BITS'(trial);
		return r;
	endfunction

	// round to nearest, ties away from zero, then keep the coordinate bits
	function automatic logic [COORD_BITS-1:0] round_coord(input logic signed [63:0] v,
		input int sh);
		logic [63:0] mag;
		logic [63:0] rnd;
		mag = v[63] ? 64'(-v) : 64'(v);
		rnd = (mag + (64'd1 << (sh - 1))) >> sh;
		if (v[63]) begin
			rnd = 64'(-rnd);
		end
		return rnd[COORD_BITS-1:0];
	endfunction

endpackage

[sv/uvs_sine.sv]
// pipelined q30 sine of a 32-bit phase, seven register stages
module uvs_sine (
	input  logic                           clk,
	input  logic                           en,
	input  logic [uvs_pkg::PHASE_BITS-1:0] phase,
	output logic signed [31:0]             sine
);

	localparam logic [30:0] COEF9_EXT = uvs_pkg::COEF9;

	logic [30:0] f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	logic [30:0] sq_s2, sq_s3, sq_s4, sq_s5, sq_s6;
	logic [30:0] p_s3, p_s4, p_s5, p_s6;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic signed [31:0] sine_s7;

	logic [61:0] sq_prod, h3_prod, h4_prod, h5_prod, h6_prod, m_prod;
	logic [31:0] h3_d, h4_d, h5_d, h6_d, m_val;

	// products of each stage
	always_comb begin
		sq_prod = 62'(f_s1) * 62'(f_s1);
		h3_prod = 62'(COEF9_EXT) * 62'(sq_s2);
		h4_prod = 62'(p_s3) * 62'(sq_s3);
		h5_prod = 62'(p_s4) * 62'(sq_s4);
		h6_prod = 62'(p_s5) * 62'(sq_s5);
		m_prod  = 62'(p_s6) * 62'(f_s6);
		h3_d    = {1'b0, uvs_pkg::COEF7} - h3_prod[61:30];
		h4_d    = {1'b0, uvs_pkg::COEF5} - h4_prod[61:30];
		h5_d    = {1'b0, uvs_pkg::COEF3} - h5_prod[61:30];
		h6_d    = {1'b0, uvs_pkg::COEF1} - h6_prod[61:30];
		m_val   = m_prod[61:30];
	end

	// quadrant fold, square, horner steps, final product and sign
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1    <= phase[30] ? 31'((32'd1 << 30) - 32'(phase[29:0])) : 31'(phase[29:0]);
			neg_s1  <= phase[31];
			sq_s2   <= sq_prod[60:30];
			f_s2    <= f_s1;
			neg_s2  <= neg_s1;
			p_s3    <= h3_d[30:0];
			sq_s3   <= sq_s2;
			f_s3    <= f_s2;
			neg_s3  <= neg_s2;
			p_s4    <= h4_d[30:0];
			sq_s4   <= sq_s3;
			f_s4    <= f_s3;
			neg_s4  <= neg_s3;
			p_s5    <= h5_d[30:0];
			sq_s5   <= sq_s4;
			f_s5    <= f_s4;
			neg_s5  <= neg_s4;
			p_s6    <= h6_d[30:0];
			f_s6    <= f_s5;
			neg_s6  <= neg_s5;
			sine_s7 <= neg_s6 ? $signed(-m_val) : $signed(m_val);
		end
	end

	assign sine = sine_s7;

endmodule

[sv/uv_sphere_cell_vertices.sv]
// uv sphere cell to six vertices: phase dividers, sine pipelines, products and rounding
// a cell yields its six vertices in order; the next cell is taken together with the last
//   vertex of the current one
// throughput: one vertex per cycle out of a 50-stage pipeline while out_stall does not hold it
// reset: subdivisions returns to 16, pipeline valid bits and cell sequencer clear
module uv_sphere_cell_vertices (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [uvs_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      lat_index,
	input  logic [7:0]                      lon_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [uvs_pkg::COORD_BITS-1:0] pos_x,
	output logic signed [uvs_pkg::COORD_BITS-1:0] pos_y,
	output logic signed [uvs_pkg::COORD_BITS-1:0] pos_z,
	output logic                            tex_u,
	output logic                            tex_v,
	output logic                            last_vertex
);

	localparam int P_DIV  = uvs_pkg::DIV_STEPS - 1;
	localparam int P_PROD = uvs_pkg::DIV_STEPS + uvs_pkg::SINE_STAGES;
	localparam int P_OUT  = uvs_pkg::PIPE_STAGES - 1;
	localparam logic [uvs_pkg::CNT_BITS-1:0] LAST_CNT =
		uvs_pkg::CNT_BITS'(uvs_pkg::VERTS_PER_CELL - 1);

	logic [8:0]                     subdiv_q;
	logic [uvs_pkg::N_BITS-1:0]     n_eff;
	logic                           cfg_wr;
	logic                           adv;
	logic                           accept;
	logic                           busy_q;
	logic [uvs_pkg::CNT_BITS-1:0]   cnt_q;
	logic [7:0]                     lat_q, lon_q;
	logic                           lat_hi, lon_hi;
	logic [8:0]                     lat_sum, lon_sum;
	logic [uvs_pkg::NUM_BITS-1:0]   lat_num, lon_num;
	uvs_pkg::side_t                 side_in;

	logic                           vld_s  [uvs_pkg::PIPE_STAGES];
	uvs_pkg::side_t                 side_s [uvs_pkg::PIPE_STAGES];

	logic [uvs_pkg::REM_BITS-1:0]   rl_s [uvs_pkg::DIV_STEPS];
	logic [uvs_pkg::REM_BITS-1:0]   rn_s [uvs_pkg::DIV_STEPS];
	logic [uvs_pkg::PHASE_BITS-1:0] ql_s [uvs_pkg::DIV_STEPS];
	logic [uvs_pkg::PHASE_BITS-1:0] qn_s [uvs_pkg::DIV_STEPS];
	logic [uvs_pkg::NUM_BITS-1:0]   nl_s [uvs_pkg::DIV_STEPS];
	logic [uvs_pkg::NUM_BITS-1:0]   nn_s [uvs_pkg::DIV_STEPS];

	uvs_pkg::div_step_t             dl0, dn0;
	logic signed [31:0]             sl, cl, sn, cn;
	logic signed [63:0]             xp_s, zp_s;
	logic signed [31:0]             yl_s;
	logic [uvs_pkg::COORD_BITS-1:0] px_s, py_s, pz_s;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == uvs_pkg::REG_SUBDIV);
	assign prdata = (paddr[2] == uvs_pkg::REG_SUBDIV) ? 32'(subdiv_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= 9'(uvs_pkg::RESET_SUBDIV);
		end else if (cfg_wr) begin
			subdiv_q <= pwdata[8:0];
		end
	end

	// clamp subdivisions into 1..max
	always_comb begin
		if (subdiv_q == 9'd0) begin
			n_eff = uvs_pkg::N_BITS'(1);
		end else if (32'(subdiv_q) > uvs_pkg::MAX_SUBDIVISIONS) begin
			n_eff = uvs_pkg::N_BITS'(uvs_pkg::MAX_SUBDIVISIONS);
		end else begin
			n_eff = uvs_pkg::N_BITS'(subdiv_q);
		end
	end

	// pipeline advances unless the output holds a stalled vertex
	assign adv      = !(out_valid && out_stall);
	assign in_stall = busy_q && !(adv && cnt_q == LAST_CNT);
	assign accept   = in_valid && !in_stall;

	// cell sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (adv && busy_q) begin
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lat_q <= lat_index;
			lon_q <= lon_index;
		end
	end

	// corner order v0 v1 v2 v0 v2 v3
	always_comb begin
		case (cnt_q)
			3'd0:    begin lat_hi = 1'b0; lon_hi = 1'b0; end
			3'd1:    begin lat_hi = 1'b1; lon_hi = 1'b0; end
			3'd2:    begin lat_hi = 1'b1; lon_hi = 1'b1; end
			3'd3:    begin lat_hi = 1'b0; lon_hi = 1'b0; end
			3'd4:    begin lat_hi = 1'b1; lon_hi = 1'b1; end
			3'd5:    begin lat_hi = 1'b0; lon_hi = 1'b1; end
			default: begin lat_hi = 1'b0; lon_hi = 1'b0; end
		endcase
		lat_sum      = 9'(lat_q) + 9'(lat_hi);
		lon_sum      = 9'(lon_q) + 9'(lon_hi);
		lat_num      = uvs_pkg::NUM_BITS'({lat_sum, 1'b0})
			+ uvs_pkg::NUM_BITS'(n_eff) + uvs_pkg::NUM_BITS'({n_eff, 1'b0});
		lon_num      = uvs_pkg::NUM_BITS'({lon_sum, 2'b00});
		side_in.u    = lon_hi;
		side_in.v    = !lat_hi;
		side_in.last = (cnt_q == LAST_CNT);
		dl0          = uvs_pkg::div_step('0, lat_num[uvs_pkg::NUM_BITS-1], n_eff);
		dn0          = uvs_pkg::div_step('0, lon_num[uvs_pkg::NUM_BITS-1], n_eff);
	end

	// valid bits along the whole pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < uvs_pkg::PIPE_STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= busy_q;
			for (int k = 1; k < uvs_pkg::PIPE_STAGES; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// texture and last flag ride along
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < uvs_pkg::PIPE_STAGES; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// phase = (num << 30) / n mod one turn, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			rl_s[0] <= dl0.rem;
			ql_s[0] <= uvs_pkg::PHASE_BITS'(dl0.q);
			nl_s[0] <= lat_num << 1;
			rn_s[0] <= dn0.rem;
			qn_s[0] <= uvs_pkg::PHASE_BITS'(dn0.q);
			nn_s[0] <= lon_num << 1;
			for (int k = 1; k < uvs_pkg::DIV_STEPS; k++) begin
				{ql_s[k], rl_s[k]} <= {ql_s[k-1][uvs_pkg::PHASE_BITS-2:0],
					uvs_pkg::div_step(rl_s[k-1], nl_s[k-1][uvs_pkg::NUM_BITS-1], n_eff)};
				nl_s[k] <= nl_s[k-1] << 1;
				{qn_s[k], rn_s[k]} <= {qn_s[k-1][uvs_pkg::PHASE_BITS-2:0],
					uvs_pkg::div_step(rn_s[k-1], nn_s[k-1][uvs_pkg::NUM_BITS-1], n_eff)};
				nn_s[k] <= nn_s[k-1] << 1;
			end
		end
	end

	// sine and cosine of latitude and longitude
	uvs_sine u_sin_lat (.clk(clk), .en(adv), .phase(ql_s[P_DIV]), .sine(sl));
	uvs_sine u_cos_lat (.clk(clk), .en(adv), .phase(ql_s[P_DIV] + (32'd1 << 30)), .sine(cl));
	uvs_sine u_sin_lon (.clk(clk), .en(adv), .phase(qn_s[P_DIV]), .sine(sn));
	uvs_sine u_cos_lon (.clk(clk), .en(adv), .phase(qn_s[P_DIV] + (32'd1 << 30)), .sine(cn));

	// q60 products, then rounding into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s <= 64'(cl) * 64'(cn);
			zp_s <= 64'(cl) * 64'(sn);
			yl_s <= sl;
			px_s <= uvs_pkg::round_coord(xp_s, uvs_pkg::PROD_SHIFT);
			py_s <= uvs_pkg::round_coord(64'(yl_s), uvs_pkg::SINE_SHIFT);
			pz_s <= uvs_pkg::round_coord(zp_s, uvs_pkg::PROD_SHIFT);
		end
	end

	assign out_valid   = vld_s[P_OUT];
	assign pos_x       = $signed(px_s);
	assign pos_y       = $signed(py_s);
	assign pos_z       = $signed(pz_s);
	assign tex_u       = side_s[P_OUT].u;
	assign tex_v       = side_s[P_OUT].v;
	assign last_vertex = side_s[P_OUT].last;

	// a new cell is taken only together with the last vertex of the current one
	a_accept_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && accept |-> cnt_q == LAST_CNT && adv)
		else $error("cell taken before its last vertex was issued");

	// a busy sequencer issues a vertex on every advance
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && adv |=> vld_s[0])
		else $error("vertex not issued while cell busy");

	// the closing vertex of a cell is corner v3
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_vertex |-> tex_u && tex_v)
		else $error("last vertex is not corner v3");

	// the product stage moves only together with the valid bits
	a_prod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(xp_s) && $stable(vld_s[P_PROD]))
		else $error("product stage moved during stall");

endmodule

[tb/uvs_checker.sv]
// checker: watches cell and vertex channels, predicts vertices and compares
`timescale 1ns / 1ps
module uvs_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic                                  pready,
	input  logic [uvs_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                           pwdata,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [7:0]                            lat_index,
	input  logic [7:0]                            lon_index,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [uvs_pkg::COORD_BITS-1:0] pos_x,
	input  logic signed [uvs_pkg::COORD_BITS-1:0] pos_y,
	input  logic signed [uvs_pkg::COORD_BITS-1:0] pos_z,
	input  logic                                  tex_u,
	input  logic                                  tex_v,
	input  logic                                  last_vertex,
	output int                                    fail_count,
	output int                                    pending
);

	typedef struct packed {
		logic [uvs_pkg::COORD_BITS-1:0] x;
		logic [uvs_pkg::COORD_BITS-1:0] y;
		logic [uvs_pkg::COORD_BITS-1:0] z;
		logic                           u;
		logic                           v;
		logic                           last;
	} vertex_t;

	localparam int ADDR_SUBDIV = 0;

	vertex_t    vertex_q[$];
	logic [8:0] subdiv_reg;

	assign pending = vertex_q.size();

	// sine of a phase in units of 2^-32 turn, q30 result
	function automatic longint phase_sine(input logic [31:0] ph);
		logic [63:0] f, s, p;
		f = {34'd0, ph[29:0]};
		if (ph[30]) f = (64'd1 << 30) - f;
		s = (f * f) >> 30;
		p = 64'(uvs_pkg::COEF9);
		p = 64'(uvs_pkg::COEF7) - ((p * s) >> 30);
		p = 64'(uvs_pkg::COEF5) - ((p * s) >> 30);
		p = 64'(uvs_pkg::COEF3) - ((p * s) >> 30);
		p = 64'(uvs_pkg::COEF1) - ((p * s) >> 30);
		p = (p * f) >> 30;
		return ph[31] ? -longint'(p) : longint'(p);
	endfunction

	// nearest rounding with ties away from zero
	function automatic logic [uvs_pkg::COORD_BITS-1:0] to_fixed(input longint v,
		input int sh);
		logic [63:0] mag;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		mag = (mag + ((64'd1 << sh) >> 1)) >> sh;
		if (v < 0) mag = 64'(-mag);
		return mag[uvs_pkg::COORD_BITS-1:0];
	endfunction

	function automatic vertex_t make_vertex(input logic [31:0] plat, input logic [31:0] plon,
		input logic u, input logic v, input logic last);
		longint sl, cl, sn, cn;
		vertex_t r;
		sl = phase_sine(plat);
		cl = phase_sine(plat + 32'h4000_0000);
		sn = phase_sine(plon);
		cn = phase_sine(plon + 32'h4000_0000);
		r.x = to_fixed(cl * cn, 60 - uvs_pkg::FRAC_BITS);
		r.y = to_fixed(sl, 30 - uvs_pkg::FRAC_BITS);
		r.z = to_fixed(cl * sn, 60 - uvs_pkg::FRAC_BITS);
		r.u = u;
		r.v = v;
		r.last = last;
		return r;
	endfunction

	// six corners of a cell as two triangles
	task automatic predict_cell(input logic [7:0] lat, input logic [7:0] lon);
		longint n, full;
		logic [31:0] a0, a1, o0, o1;
		n = subdiv_reg;
		if (n < 1) n = 1;
		if (n > uvs_pkg::MAX_SUBDIVISIONS) n = uvs_pkg::MAX_SUBDIVISIONS;
		full = 4 * n;
		a0 = 32'((((2 * lat + 3 * n) % full) << 30) / n);
		a1 = 32'((((2 * (lat + 1) + 3 * n) % full) << 30) / n);
		o0 = 32'((((4 * lon) % full) << 30) / n);
		o1 = 32'((((4 * (lon + 1)) % full) << 30) / n);
		vertex_q = {vertex_q, make_vertex(a0, o0, 1'b0, 1'b1, 1'b0)};
		vertex_q = {vertex_q, make_vertex(a1, o0, 1'b0, 1'b0, 1'b0)};
		vertex_q = {vertex_q, make_vertex(a1, o1, 1'b1, 1'b0, 1'b0)};
		vertex_q = {vertex_q, make_vertex(a0, o0, 1'b0, 1'b1, 1'b0)};
		vertex_q = {vertex_q, make_vertex(a1, o1, 1'b1, 1'b0, 1'b0)};
		vertex_q = {vertex_q, make_vertex(a0, o1, 1'b1, 1'b1, 1'b1)};
	endtask

	// register shadow, cell prediction, vertex compare
	always @(posedge clk or negedge arst_n) begin
		vertex_t got, want;
		if (!arst_n) begin
			subdiv_reg = 9'(uvs_pkg::RESET_SUBDIV);
			fail_count = 0;
			vertex_q.delete();
		end else begin
			if (psel && penable && pwrite && pready
				&& paddr == uvs_pkg::ADDR_BITS'(ADDR_SUBDIV))
				subdiv_reg = pwdata[8:0];
			if (in_valid && !in_stall)
				predict_cell(lat_index, lon_index);
			if (out_valid && !out_stall) begin
				got = {pos_x, pos_y, pos_z, tex_u, tex_v, last_vertex};
				if (vertex_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected vertex %h", got);
				end else begin
					want = vertex_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"vertex mismatch: exp x=%h y=%h z=%h u=%b v=%b l=%b,",
								" got x=%h y=%h z=%h u=%b v=%b l=%b"},
								want.x, want.y, want.z, want.u, want.v, want.last,
								got.x, got.y, got.z, got.u, got.v, got.last);
					end
				end
			end
		end
	end
endmodule

[tb/testbench.sv]
// top: clock, reset, register writes, cell stimulus and verdict
`timescale 1ns / 1ps
module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [uvs_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic [7:0] lat_index = '0, lon_index = '0;
	logic out_valid, out_stall = 1'b0;
	logic signed [uvs_pkg::COORD_BITS-1:0] pos_x, pos_y, pos_z;
	logic tex_u, tex_v, last_vertex;
	int fail_count, pending;
	int rx_wait = 0;

	localparam int ADDR_SUBDIV = 0;
	localparam int ADDR_UNUSED = 4;

	always #5 clk = ~clk;

	uv_sphere_cell_vertices dut (.*);
	uvs_checker chk (.*);

	// write a register in setup and access cycles
	task automatic write_reg(input int addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= uvs_pkg::ADDR_BITS'(addr); pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// offer one cell after a random gap and wait for acceptance
	task automatic send_cell(input logic [7:0] lat, input logic [7:0] lon);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1; lat_index <= lat; lon_index <= lon;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait until every expected vertex has come
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// receiver draws a wait after every vertex it takes
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if ($urandom_range(0, 1) == 0) rx_wait = 0;
			else rx_wait = int'($urandom_range(0, 18));
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		out_stall <= (rx_wait != 0);
	end

	initial begin
		int sub_list[6];
		sub_list = '{1, 256, 3, 0, 511, 16};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed cells under reset subdivisions
		send_cell(8'd0, 8'd0);
		send_cell(8'd15, 8'd15);
		send_cell(8'd255, 8'd255);
		send_cell(8'd7, 8'd200);
		send_cell(8'hAA, 8'h55);
		send_cell(8'h55, 8'hAA);
		drain();
		foreach (sub_list[k]) begin
			write_reg(ADDR_SUBDIV, sub_list[k]);
			write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
			send_cell(8'd0, 8'd0);
			send_cell(8'd255, 8'd255);
			for (int i = 0; i < 25; i++) begin
				int lim;
				lim = (sub_list[k] >= 1 && sub_list[k] <= 255) ? sub_list[k] - 1 : 255;
				if ($urandom_range(0, 4) == 0)
					send_cell(8'($urandom), 8'($urandom));
				else
					send_cell(8'($urandom_range(0, lim)), 8'($urandom_range(0, lim)));
			end
			drain();
		end
		if (fail_count == 0)
			$display("** uv_sphere_cell_vertices: PASSED **");
		else
			$display("** uv_sphere_cell_vertices: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** uv_sphere_cell_vertices: FAILED **");
		$finish;
	end
endmodule

[files.f]
sv/uvs_pkg.sv
sv/uvs_sine.sv
sv/uv_sphere_cell_vertices.sv
tb/uvs_checker.sv
tb/testbench.sv
